// ===== rtl/core/oai_pkg.sv =====
// Package for the ordered array store: sizes, codes and word types.
// Used by every module under rtl/core; depends on nothing.
package oai_pkg;

  // Store geometry
  localparam int DEPTH   = 1024;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 11;
  localparam int CAP_W   = 11;
  localparam int VAL_W   = 32;
  localparam int FOUND_W = 10;
  localparam int ECNT_W  = 11;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Priority tree: groups of 32 match bits, then groups of 32 groups
  localparam int GRP_N   = 32;
  localparam int GRP_IW  = $clog2(GRP_N);
  localparam int NGRP    = (DEPTH + GRP_N - 1) / GRP_N;
  localparam int NSUP    = (NGRP + GRP_N - 1) / GRP_N;
  localparam int DEPTH_P = NGRP * GRP_N;
  localparam int NGRP_P  = NSUP * GRP_N;
  localparam int GI_W    = $clog2(NGRP_P);

  // Register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CAP_LIMIT = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_CMP  = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EXEC  = 3'd1,
    S_SRCH1 = 3'd2,
    S_SRCH2 = 3'd3,
    S_SRCH3 = 3'd4,
    S_DONE  = 3'd5
  } state_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        cnt;
    logic signed [VAL_W-1:0] val;
  } cell_ctl_t;

  typedef struct packed {
    req_kind_t               req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [FOUND_W-1:0]  found_index;
    logic [ECNT_W-1:0]   entry_count;
  } out_word_t;

endpackage

// ===== rtl/core/oai_cell.sv =====
// One storage cell of the chain: holds an entry, shifts from a neighbor,
// and flags a match. Depends on oai_pkg.
module oai_cell import oai_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CMP_W-1:0]        cell_idx,
  input  logic signed [VAL_W-1:0] lower_data,
  input  logic signed [VAL_W-1:0] upper_data,
  output logic signed [VAL_W-1:0] data_r,
  output logic                    match_r
);

  logic signed [VAL_W-1:0] data_nxt;
  logic                    match_nxt;
  logic [CMP_W:0]          idx_p1;

  assign idx_p1 = {1'b0, cell_idx} + (CMP_W+1)'(1);

  // Per-cell decision from the broadcast request
  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    case (ctl.op)
      CELL_INS: begin
        if (cell_idx == ctl.pos) begin
          data_nxt = ctl.val;
        end else if (cell_idx > ctl.pos && cell_idx <= ctl.cnt) begin
          data_nxt = lower_data;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= ctl.pos && idx_p1 < {1'b0, ctl.cnt}) begin
          data_nxt = upper_data;
        end
      end
      CELL_CMP: begin
        match_nxt = (cell_idx < ctl.cnt) && (data_r == ctl.val);
      end
      default: begin
      end
    endcase
  end

  // Entry and match flag are payload: no reset
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

// ===== rtl/core/oai_pgrp.sv =====
// Registered priority encoder over one group of match flags.
// Depends on oai_pkg.
module oai_pgrp import oai_pkg::*; (
  input  logic              clk,
  input  logic [GRP_N-1:0]  req,
  output logic              any_r,
  output logic [GRP_IW-1:0] idx_r
);

  logic              any_nxt;
  logic [GRP_IW-1:0] idx_nxt;

  // Lowest set bit wins
  always_comb begin
    any_nxt = |req;
    idx_nxt = '0;
    for (int i = GRP_N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx_nxt = GRP_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    any_r <= any_nxt;
    idx_r <= idx_nxt;
  end

endmodule

// ===== rtl/core/ordered_array_insert_delete_search.sv =====
// Insert, delete and unknown requests pass the execute and done states before out_valid rises;
// a non-empty search also waits in the search states for the match flags and two tree levels.
// One request is taken at a time: in_stall holds new words off until the sequencer is back in idle,
// and a held output keeps the sequencer in the done state.
// Reset (rst_n low, synchronous): count cleared, capacity_limit back to 1024, no clearing pass.
// Top level: cell chain, priority tree, sequencer, APB register. Uses oai_pkg, oai_cell, oai_pgrp.
module ordered_array_insert_delete_search import oai_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  state_t           state_r, state_nxt;
  in_word_t         req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  out_word_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r;

  logic             out_free, out_load, accept;
  cell_ctl_t        ctl;
  out_word_t        exec_res, srch_res;
  logic [CNT_W-1:0] exec_cnt;
  cell_op_t         exec_op;

  logic [CMP_W-1:0] cap_ext, lim, pos_ext, cnt_ext;
  logic             is_empty;

  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH_P-1:0]      match_v;
  logic [NGRP_P-1:0]       grp_any;
  logic [GRP_IW-1:0]       grp_idx [NGRP_P];
  logic [NSUP-1:0]         sup_any;
  logic [GRP_IW-1:0]       sup_idx [NSUP];

  // Handshakes
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && out_free;

  // Limit checks
  assign cap_ext  = CMP_W'(cap_r);
  assign lim      = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign pos_ext  = CMP_W'(req_r.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign is_empty = (count_r == '0);

  // Request decode: status, new count and cell operation
  always_comb begin
    exec_res.status      = ST_OK;
    exec_res.found_index = '0;
    exec_cnt             = count_r;
    exec_op              = CELL_HOLD;
    case (req_r.req_type)
      REQ_INSERT: begin
        if (!(cnt_ext < lim)) begin
          exec_res.status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          exec_res.status = ST_BADPOS;
        end else begin
          exec_cnt = count_r + CNT_W'(1);
          exec_op  = CELL_INS;
        end
      end
      REQ_DELETE: begin
        if (is_empty) begin
          exec_res.status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          exec_res.status = ST_BADPOS;
        end else begin
          exec_cnt = count_r - CNT_W'(1);
          exec_op  = CELL_DEL;
        end
      end
      REQ_SEARCH: begin
        if (is_empty) begin
          exec_res.status = ST_EMPTY;
        end else begin
          exec_res.status = ST_NOTFOUND;
          exec_op         = CELL_CMP;
        end
      end
      default: begin
        exec_res.status = ST_BADPOS;
      end
    endcase
    exec_res.entry_count = ECNT_W'(exec_cnt);
  end

  // Cell broadcast
  always_comb begin
    ctl.op  = (state_r == S_EXEC) ? exec_op : CELL_HOLD;
    ctl.pos = pos_ext;
    ctl.cnt = cnt_ext;
    ctl.val = req_r.value;
  end

  // Chain of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [VAL_W-1:0] lo_d, up_d;
    if (k == 0) begin : g_lo0
      assign lo_d = '0;
    end else begin : g_lo
      assign lo_d = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_upn
      assign up_d = '0;
    end else begin : g_up
      assign up_d = cell_data[k+1];
    end
    oai_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (CMP_W'(k)),
      .lower_data (lo_d),
      .upper_data (up_d),
      .data_r     (cell_data[k]),
      .match_r    (match_v[k])
    );
  end

  if (DEPTH_P > DEPTH) begin : g_mpad
    assign match_v[DEPTH_P-1:DEPTH] = '0;
  end

  // First tree level: one encoder per group of cells
  for (genvar g = 0; g < NGRP_P; g++) begin : g_grp
    if (g < NGRP) begin : g_real
      oai_pgrp u_grp (
        .clk   (clk),
        .req   (match_v[g*GRP_N +: GRP_N]),
        .any_r (grp_any[g]),
        .idx_r (grp_idx[g])
      );
    end else begin : g_pad
      assign grp_any[g] = 1'b0;
      assign grp_idx[g] = '0;
    end
  end

  // Second tree level: one encoder per group of groups
  for (genvar s = 0; s < NSUP; s++) begin : g_sup
    oai_pgrp u_sup (
      .clk   (clk),
      .req   (grp_any[s*GRP_N +: GRP_N]),
      .any_r (sup_any[s]),
      .idx_r (sup_idx[s])
    );
  end

  // Final pick among the few top-level groups
  always_comb begin
    logic [GI_W-1:0] gi;
    logic            hit;
    int              fidx;
    hit  = 1'b0;
    fidx = 0;
    gi   = '0;
    for (int s = NSUP - 1; s >= 0; s--) begin
      if (sup_any[s]) begin
        hit  = 1'b1;
        gi   = GI_W'(s * GRP_N) + GI_W'(sup_idx[s]);
        fidx = s * GRP_N * GRP_N + int'(sup_idx[s]) * GRP_N + int'(grp_idx[gi]);
      end
    end
    srch_res.status      = hit ? ST_OK : ST_NOTFOUND;
    srch_res.found_index = hit ? FOUND_W'(fidx) : '0;
    srch_res.entry_count = ECNT_W'(count_r);
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (exec_op == CELL_CMP) ? S_SRCH1 : S_DONE;
      end
      S_SRCH1: state_nxt = S_SRCH2;
      S_SRCH2: state_nxt = S_SRCH3;
      S_SRCH3: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    count_nxt = count_r;
    res_nxt   = res_r;
    case (state_r)
      S_EXEC: begin
        count_nxt = exec_cnt;
        res_nxt   = exec_res;
      end
      S_SRCH3: begin
        res_nxt = srch_res;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_CAP_LIMIT) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAP_LIMIT) ? DATA_W'(cap_r) : '0;

endmodule

// ===== rtl/core/oai_checker.sv =====
// Port-level checks for the ordered array store, bound to the top level.
// Depends on oai_pkg and ordered_array_insert_delete_search.
module oai_checker import oai_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // Held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held output word changed");

  // One request in flight: stall right after an accepted word
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // Only a successful search reports an index
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.found_index == '0)
    else $error("index on failed request");

  // Empty status means an empty store
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.entry_count == '0)
    else $error("empty status with entries");

endmodule

bind ordered_array_insert_delete_search oai_checker u_oai_checker (.*);
